// File: rtl/mla_pkg.sv
// Shared types and constants for the motion/light alarm sequencer.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package mla_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int TIMER_BITS    = 20;
  localparam int LIGHT_BITS    = 24;
  localparam int LVAL_BITS     = LIGHT_BITS + 1;
  localparam int GTHR_BITS     = 16;
  localparam int MTHR_BITS     = 32;
  localparam int SQ_BITS       = 2 * SAMPLE_BITS;
  localparam int SUM_BITS      = SQ_BITS + 2;
  localparam int NUM_AXES      = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int GCMP_BITS     = (SAMPLE_BITS + 1 > GTHR_BITS) ? SAMPLE_BITS + 1 : GTHR_BITS;
  localparam int MCMP_BITS     = (SUM_BITS > MTHR_BITS) ? SUM_BITS : MTHR_BITS;

  localparam logic [LIGHT_BITS-1:0] LIGHT_THR_RST  = LIGHT_BITS'(1);
  localparam logic [GTHR_BITS-1:0]  GYRO_THR_RST   = GTHR_BITS'(10000);
  localparam logic [MTHR_BITS-1:0]  MOTION_THR_RST = MTHR_BITS'(100000000);
  localparam logic [TIMER_BITS-1:0] BUZZ_TICKS_RST   = TIMER_BITS'(2);
  localparam logic [TIMER_BITS-1:0] WAIT_TICKS_RST   = TIMER_BITS'(2);
  localparam logic [TIMER_BITS-1:0] ACTIVE_TICKS_RST = TIMER_BITS'(16);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LIGHT_THR    = 3'd0,
    CFG_GYRO_THR     = 3'd1,
    CFG_MOTION_THR   = 3'd2,
    CFG_BUZZ_TICKS   = 3'd3,
    CFG_WAIT_TICKS   = 3'd4,
    CFG_ACTIVE_TICKS = 3'd5,
    CFG_TONE_HZ      = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BUZZ = 2'd1,
    MODE_WAIT = 2'd2
  } mode_e;

  typedef struct packed {
    logic [LIGHT_BITS-1:0] light_thr;
    logic [MTHR_BITS-1:0]  motion_thr;
    logic [TIMER_BITS-1:0] buzz_ticks;
    logic [TIMER_BITS-1:0] wait_ticks;
    logic [TIMER_BITS-1:0] active_ticks;
  } cfg_t;

  typedef struct packed {
    logic [SQ_BITS-1:0] acc_sq;
    logic               gyro_move;
  } lane_res_t;

  typedef struct packed {
    logic                  prime;
    logic                  tick;
    logic [LVAL_BITS-1:0]  light;
  } s1_ctl_t;

endpackage

`default_nettype wire

// File: rtl/mla_lane.sv
// One axis lane: registered accel square and gyro change test against the last sample.
// Depends on mla_pkg.
`default_nettype none

module mla_lane (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic signed [mla_pkg::SAMPLE_BITS-1:0] acc_i,
  input  wire logic signed [mla_pkg::SAMPLE_BITS-1:0] gyro_i,
  input  wire logic [mla_pkg::GTHR_BITS-1:0]       gyro_thr_i,
  output mla_pkg::lane_res_t                       lane_o
);

  logic signed [mla_pkg::SAMPLE_BITS-1:0] last_gyro_q;
  logic signed [mla_pkg::SQ_BITS-1:0]     acc_sq;
  logic signed [mla_pkg::SAMPLE_BITS:0]   gdiff;
  logic [mla_pkg::SAMPLE_BITS:0]          gabs;
  logic                                   gmove;
  mla_pkg::lane_res_t                     res_q;

  always_comb begin
    acc_sq = acc_i * acc_i;
    gdiff  = {gyro_i[mla_pkg::SAMPLE_BITS-1], gyro_i}
           - {last_gyro_q[mla_pkg::SAMPLE_BITS-1], last_gyro_q};
    gabs   = gdiff[mla_pkg::SAMPLE_BITS] ? (mla_pkg::SAMPLE_BITS+1)'(-gdiff)
                                         : (mla_pkg::SAMPLE_BITS+1)'(gdiff);
    gmove  = mla_pkg::GCMP_BITS'(gabs) > mla_pkg::GCMP_BITS'(gyro_thr_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_gyro_q <= '0;
    end else if (en_i) begin
      last_gyro_q <= gyro_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.acc_sq    <= $unsigned(acc_sq);
      res_q.gyro_move <= gmove;
    end
  end

  assign lane_o = res_q;

endmodule

`default_nettype wire

// File: rtl/mla_merge.sv
// Merge stage: sums the lane squares, runs the motion and light tests and the alarm
// state machine, and holds the result register. Depends on mla_pkg.
`default_nettype none

module mla_merge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire mla_pkg::cfg_t        cfg_i,
  input  wire mla_pkg::s1_ctl_t     ctl_i,
  input  wire mla_pkg::lane_res_t [mla_pkg::NUM_AXES-1:0] lanes_i,
  output logic [1:0]                alarm_mode_o,
  output logic                      buzzer_on_o,
  output logic                      motion_seen_o,
  output logic                      light_changed_o
);

  localparam int TB = mla_pkg::TIMER_BITS;
  localparam int LB = mla_pkg::LVAL_BITS;

  mla_pkg::mode_e        mode_q, mode_d;
  logic [TB-1:0]         buzz_q, buzz_d, wait_q, wait_d, act_q, act_d;
  logic [TB-1:0]         buzz_t, wait_t, act_t;
  logic [LB-1:0]         last_light_q, last_light_d;
  logic [mla_pkg::SUM_BITS-1:0] mag;
  logic                  motion, lchg, gmove;
  logic signed [LB:0]    ldiff;
  logic [LB:0]           labs;
  logic                  buzzer;
  logic [1:0]            res_mode_q;
  logic                  res_buzz_q, res_motion_q, res_lchg_q;

  // detection
  always_comb begin
    mag = mla_pkg::SUM_BITS'(lanes_i[0].acc_sq) + mla_pkg::SUM_BITS'(lanes_i[1].acc_sq)
        + mla_pkg::SUM_BITS'(lanes_i[2].acc_sq);
    gmove  = lanes_i[0].gyro_move | lanes_i[1].gyro_move | lanes_i[2].gyro_move;
    motion = !ctl_i.prime &&
             ((mla_pkg::MCMP_BITS'(mag) > mla_pkg::MCMP_BITS'(cfg_i.motion_thr)) || gmove);
    ldiff  = $signed({ctl_i.light[LB-1], ctl_i.light})
           - $signed({last_light_q[LB-1], last_light_q});
    labs   = ldiff[LB] ? (LB+1)'(-ldiff) : (LB+1)'(ldiff);
    lchg   = !ctl_i.prime && !motion && (labs > (LB+1)'(cfg_i.light_thr));
    last_light_d = (ctl_i.prime || lchg) ? ctl_i.light : last_light_q;
  end

  // next state
  always_comb begin
    buzz_t = buzz_q;
    wait_t = wait_q;
    act_t  = act_q;
    if (ctl_i.tick) begin
      if (buzz_q != '0) buzz_t = buzz_q - TB'(1);
      if (wait_q != '0) wait_t = wait_q - TB'(1);
      if (act_q != '0)  act_t  = act_q - TB'(1);
    end
    mode_d = mode_q;
    buzz_d = buzz_t;
    wait_d = wait_t;
    act_d  = act_t;
    if ((motion || lchg) && mode_q == mla_pkg::MODE_IDLE) begin
      act_d  = cfg_i.active_ticks;
      mode_d = mla_pkg::MODE_BUZZ;
      buzz_d = cfg_i.buzz_ticks;
    end
    if (mode_d == mla_pkg::MODE_BUZZ && buzz_d == '0 && act_d != '0) begin
      mode_d = mla_pkg::MODE_WAIT;
      wait_d = cfg_i.wait_ticks;
    end
    if (mode_d == mla_pkg::MODE_WAIT && wait_d == '0 && act_d != '0) begin
      mode_d = mla_pkg::MODE_BUZZ;
      buzz_d = cfg_i.buzz_ticks;
    end
    if (act_d == '0) mode_d = mla_pkg::MODE_IDLE;
    if (ctl_i.prime) begin
      mode_d = mode_q;
      buzz_d = buzz_q;
      wait_d = wait_q;
      act_d  = act_q;
    end
  end

  // outputs
  always_comb begin
    buzzer = (mode_d == mla_pkg::MODE_BUZZ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= mla_pkg::MODE_IDLE;
      buzz_q       <= '0;
      wait_q       <= '0;
      act_q        <= '0;
      last_light_q <= '0;
    end else if (en_i) begin
      mode_q       <= mode_d;
      buzz_q       <= buzz_d;
      wait_q       <= wait_d;
      act_q        <= act_d;
      last_light_q <= last_light_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_mode_q   <= mode_d;
      res_buzz_q   <= buzzer;
      res_motion_q <= motion;
      res_lchg_q   <= lchg;
    end
  end

  assign alarm_mode_o    = res_mode_q;
  assign buzzer_on_o     = res_buzz_q;
  assign motion_seen_o   = res_motion_q;
  assign light_changed_o = res_lchg_q;

endmodule

`default_nettype wire

// File: rtl/motion_light_alarm_sequencer.sv
// Top level of the motion/light alarm sequencer: config registers, three axis lanes,
// merge stage and the two-stage valid/stall pipeline. Depends on mla_pkg, mla_lane, mla_merge.
//
//   channel | direction | transfer when         | payload
//   in      | input     | in_valid_i & !stall  | tick, gyro_x/y/z, acc_x/y/z, light
//   out     | output    | out_valid_o & !stall | alarm_mode, buzzer_on, motion_seen, light_changed
//   cfg     | input     | cfg_we_i             | cfg_index_i, cfg_wdata_i
//
// One item per clock while not stalled; each item passes the lane stage, then the merge/result register.
// The alarm state loop closes inside the merge stage.
// Reset clears pipeline valids, stored samples and timers; config returns to defaults.
// in_stall_o rises only when the lane stage is full and the result is stalled.
// The tone setting is accepted on the config port and has no output here.
`default_nettype none

module motion_light_alarm_sequencer (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [mla_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  wire logic [mla_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 tick_i,
  input  wire logic signed [mla_pkg::SAMPLE_BITS-1:0] gyro_x_i,
  input  wire logic signed [mla_pkg::SAMPLE_BITS-1:0] gyro_y_i,
  input  wire logic signed [mla_pkg::SAMPLE_BITS-1:0] gyro_z_i,
  input  wire logic signed [mla_pkg::SAMPLE_BITS-1:0] acc_x_i,
  input  wire logic signed [mla_pkg::SAMPLE_BITS-1:0] acc_y_i,
  input  wire logic signed [mla_pkg::SAMPLE_BITS-1:0] acc_z_i,
  input  wire logic [mla_pkg::LIGHT_BITS-1:0]       light_level_i,
  input  wire logic                                 light_valid_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [1:0]                                alarm_mode_o,
  output logic                                      buzzer_on_o,
  output logic                                      motion_seen_o,
  output logic                                      light_changed_o
);

  mla_pkg::cfg_t                 cfg_q;
  logic [mla_pkg::GTHR_BITS-1:0] gyro_thr_q;
  logic                          primed_q, s1_valid_q, out_valid_q;
  mla_pkg::s1_ctl_t              s1_q;
  logic                          out_en, s1_en, in_xfer, merge_en;
  mla_pkg::lane_res_t [mla_pkg::NUM_AXES-1:0] lanes;

  assign out_en   = !out_valid_q || !out_stall_i;
  assign s1_en    = !s1_valid_q || out_en;
  assign in_xfer  = in_valid_i && s1_en;
  assign merge_en = out_en && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_thr    <= mla_pkg::LIGHT_THR_RST;
      cfg_q.motion_thr   <= mla_pkg::MOTION_THR_RST;
      cfg_q.buzz_ticks   <= mla_pkg::BUZZ_TICKS_RST;
      cfg_q.wait_ticks   <= mla_pkg::WAIT_TICKS_RST;
      cfg_q.active_ticks <= mla_pkg::ACTIVE_TICKS_RST;
      gyro_thr_q         <= mla_pkg::GYRO_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mla_pkg::CFG_LIGHT_THR:    cfg_q.light_thr    <= cfg_wdata_i[mla_pkg::LIGHT_BITS-1:0];
        mla_pkg::CFG_GYRO_THR:     gyro_thr_q         <= cfg_wdata_i[mla_pkg::GTHR_BITS-1:0];
        mla_pkg::CFG_MOTION_THR:   cfg_q.motion_thr   <= cfg_wdata_i[mla_pkg::MTHR_BITS-1:0];
        mla_pkg::CFG_BUZZ_TICKS:   cfg_q.buzz_ticks   <= cfg_wdata_i[mla_pkg::TIMER_BITS-1:0];
        mla_pkg::CFG_WAIT_TICKS:   cfg_q.wait_ticks   <= cfg_wdata_i[mla_pkg::TIMER_BITS-1:0];
        mla_pkg::CFG_ACTIVE_TICKS: cfg_q.active_ticks <= cfg_wdata_i[mla_pkg::TIMER_BITS-1:0];
        mla_pkg::CFG_TONE_HZ:      ;
        default:                   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) primed_q <= 1'b1;
      if (s1_en)   s1_valid_q <= in_valid_i;
      if (out_en)  out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q.prime <= !primed_q;
      s1_q.tick  <= tick_i;
      s1_q.light <= light_valid_i ? {1'b0, light_level_i} : '1;
    end
  end

  mla_lane u_lane_x (
    .clk_i, .rst_ni, .en_i(in_xfer), .acc_i(acc_x_i), .gyro_i(gyro_x_i),
    .gyro_thr_i(gyro_thr_q), .lane_o(lanes[0])
  );
  mla_lane u_lane_y (
    .clk_i, .rst_ni, .en_i(in_xfer), .acc_i(acc_y_i), .gyro_i(gyro_y_i),
    .gyro_thr_i(gyro_thr_q), .lane_o(lanes[1])
  );
  mla_lane u_lane_z (
    .clk_i, .rst_ni, .en_i(in_xfer), .acc_i(acc_z_i), .gyro_i(gyro_z_i),
    .gyro_thr_i(gyro_thr_q), .lane_o(lanes[2])
  );

  mla_merge u_merge (
    .clk_i, .rst_ni, .en_i(merge_en), .cfg_i(cfg_q), .ctl_i(s1_q), .lanes_i(lanes),
    .alarm_mode_o, .buzzer_on_o, .motion_seen_o, .light_changed_o
  );

  assign in_stall_o  = !s1_en;
  assign out_valid_o = out_valid_q;

  a_buzz_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (buzzer_on_o == (alarm_mode_o == mla_pkg::MODE_BUZZ)))
    else $error("buzzer does not follow mode");

  a_light_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && light_changed_o) |-> !motion_seen_o)
    else $error("light test ran with motion seen");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in pipeline");

endmodule

`default_nettype wire
